// ===== hdl/cuid_pkg.sv =====
// shared types and constants of the card uid read sequencer
`timescale 1ns / 1ps

package cuid_pkg;

    // input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DONE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_DELAY  = 2'd1;
    localparam logic [1:0] KIND_RESULT = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TIMEOUT    = 3'd1;
    localparam logic [2:0] ST_ERROR      = 3'd2;
    localparam logic [2:0] ST_SHORT_RPLY = 3'd3;
    localparam logic [2:0] ST_SHORT_UID  = 3'd4;
    localparam logic [2:0] ST_BCC_FAIL   = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST     = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] RST_POLL_LIMIT = 16'd1000;
    localparam logic [7:0]  RST_WAIT_MASK  = 8'h30;
    localparam logic [7:0]  RST_ERROR_MASK = 8'h1B;
    localparam logic [6:0]  RST_IRQ_ENABLE = 7'h77;
    localparam logic [7:0]  RST_REQUEST    = 8'h26;

    // reader register map
    localparam logic [5:0] REG_COMMAND     = 6'h01;
    localparam logic [5:0] REG_COM_IEN     = 6'h02;
    localparam logic [5:0] REG_COM_IRQ     = 6'h04;
    localparam logic [5:0] REG_ERROR       = 6'h06;
    localparam logic [5:0] REG_FIFO_DATA   = 6'h09;
    localparam logic [5:0] REG_FIFO_LEVEL  = 6'h0A;
    localparam logic [5:0] REG_CONTROL     = 6'h0C;
    localparam logic [5:0] REG_BIT_FRAMING = 6'h0D;

    // reader command and frame bytes
    localparam logic [7:0] RDR_CMD_IDLE     = 8'h00;
    localparam logic [7:0] RDR_CMD_TRANSCVE = 8'h0C;
    localparam logic [7:0] FRAME_SHORT      = 8'h07;
    localparam logic [7:0] FRAME_FULL       = 8'h00;
    localparam logic [7:0] SEL_CASCADE1     = 8'h93;
    localparam logic [7:0] NVB_ANTICOLL     = 8'h20;
    localparam logic [7:0] BIT7_MASK        = 8'h80;
    localparam logic [7:0] LOW7_MASK        = 8'h7F;

    localparam int unsigned BITS_W = 10;
    localparam logic [BITS_W-1:0] MIN_UID_BITS   = 10'd40;
    localparam logic [BITS_W-1:0] MIN_REPLY_BITS = 10'd16;
    localparam int unsigned NUM_KEPT = 5;

    typedef enum logic [4:0] {
        PH_IDLE, PH_FRAME_PRE, PH_IEN, PH_IRQ_RD, PH_IRQ_WR, PH_FL_RD, PH_FL_WR,
        PH_TX0, PH_TX1, PH_CMD, PH_BF_RD, PH_BF_WR, PH_POLL, PH_DELAY,
        PH_BFC_RD, PH_BFC_WR, PH_BFC_RD_T, PH_BFC_WR_T, PH_ERR, PH_LVL, PH_CTRL,
        PH_FIFO, PH_IDLECMD, PH_POST_OK, PH_POST_TO, PH_POST_ERR
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_GO,
        ACT_FINISH
    } action_t;

    typedef struct packed {
        logic [15:0] poll_limit;
        logic [7:0]  wait_irq_mask;
        logic [7:0]  error_bit_mask;
        logic [6:0]  irq_enable_bits;
        logic [7:0]  request_code;
    } cuid_cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        write_flag;
        logic [5:0]  reg_addr;
        logic [7:0]  write_data;
        logic [2:0]  status;
        logic [31:0] card_uid;
    } cuid_res_t;

endpackage

// ===== hdl/cuid_if.sv =====
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps

interface cuid_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] read_data;

    modport source (output valid, output cmd, output read_data, input ready);
    modport sink (input valid, input cmd, input read_data, output ready);
endinterface

interface cuid_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        write_flag;
    logic [5:0]  reg_addr;
    logic [7:0]  write_data;
    logic [2:0]  status;
    logic [31:0] card_uid;

    modport source (output valid, output kind, output write_flag, output reg_addr,
                    output write_data, output status, output card_uid, input ready);
    modport sink (input valid, input kind, input write_flag, input reg_addr,
                  input write_data, input status, input card_uid, output ready);
endinterface

// ===== hdl/cuid_cfg_regs.sv =====
// configuration register file of the card uid read sequencer
`timescale 1ns / 1ps

module cuid_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cuid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cuid_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output cuid_pkg::cuid_cfg_t             cfg
);
    import cuid_pkg::*;

    cuid_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_limit      <= RST_POLL_LIMIT;
            cfg_reg.wait_irq_mask   <= RST_WAIT_MASK;
            cfg_reg.error_bit_mask  <= RST_ERROR_MASK;
            cfg_reg.irq_enable_bits <= RST_IRQ_ENABLE;
            cfg_reg.request_code    <= RST_REQUEST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_POLL_LIMIT: cfg_reg.poll_limit      <= cfg_wr_data[15:0];
                CFG_WAIT_MASK:  cfg_reg.wait_irq_mask   <= cfg_wr_data[7:0];
                CFG_ERROR_MASK: cfg_reg.error_bit_mask  <= cfg_wr_data[7:0];
                CFG_IRQ_ENABLE: cfg_reg.irq_enable_bits <= cfg_wr_data[6:0];
                CFG_REQUEST:    cfg_reg.request_code    <= cfg_wr_data[7:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/cuid_seq_core.sv =====
// sequencer state and the combinational step from one input word to its result
`timescale 1ns / 1ps

module cuid_seq_core #(
    parameter int unsigned FIFO_READ_MAX = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cuid_pkg::cuid_cfg_t cfg,
    input  logic                step_en,
    input  logic [1:0]          cmd,
    input  logic [7:0]          read_data,
    output logic                res_valid,
    output cuid_pkg::cuid_res_t res
);
    import cuid_pkg::*;

    localparam int unsigned CNT_W = $clog2(FIFO_READ_MAX + 1);
    localparam logic [6:0] READ_MAX7 = 7'(FIFO_READ_MAX);
    localparam logic [2:0] NUM_KEPT3 = 3'(NUM_KEPT);

    phase_t             phase_reg, phase_next;
    logic               in_ac_reg, in_ac_next;
    logic [15:0]        poll_count_reg, poll_count_next;
    logic [CNT_W-1:0]   fifo_count_reg, fifo_count_next;
    logic [2:0]         byte_index_reg, byte_index_next;
    logic [6:0]         level_reg, level_next;
    logic [BITS_W-1:0]  reply_bits_reg, reply_bits_next;
    logic [7:0]         reply_bytes_reg [NUM_KEPT];
    logic               store_en;

    action_t            action;
    logic [2:0]         fin_status;
    logic [15:0]        poll_inc;
    logic [6:0]         level_m1;
    logic [CNT_W-1:0]   fifo_dec;
    logic [7:0]         bcc;
    logic [31:0]        uid;

    assign poll_inc = (poll_count_reg == 16'hFFFF) ? poll_count_reg : poll_count_reg + 16'd1;
    assign level_m1 = level_reg - 7'd1;
    assign fifo_dec = (fifo_count_reg != '0) ? fifo_count_reg - CNT_W'(1) : fifo_count_reg;
    assign bcc = reply_bytes_reg[0] ^ reply_bytes_reg[1] ^ reply_bytes_reg[2]
               ^ reply_bytes_reg[3];
    assign uid = {reply_bytes_reg[3], reply_bytes_reg[2], reply_bytes_reg[1],
                  reply_bytes_reg[0]};

    // next state and step action
    always_comb
    begin
        phase_next      = phase_reg;
        in_ac_next      = in_ac_reg;
        poll_count_next = poll_count_reg;
        fifo_count_next = fifo_count_reg;
        byte_index_next = byte_index_reg;
        level_next      = level_reg;
        reply_bits_next = reply_bits_reg;
        store_en        = 1'b0;
        action          = ACT_NONE;
        fin_status      = ST_OK;
        if (step_en)
        begin
            if (cmd == CMD_START)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    in_ac_next = 1'b0;
                    phase_next = PH_FRAME_PRE;
                    action     = ACT_GO;
                end
            end
            else if (cmd == CMD_TICK)
            begin
                if (phase_reg == PH_DELAY)
                begin
                    poll_count_next = poll_inc;
                    phase_next = (poll_inc >= cfg.poll_limit) ? PH_BFC_RD_T : PH_POLL;
                    action     = ACT_GO;
                end
            end
            else if (cmd == CMD_DONE && phase_reg != PH_IDLE && phase_reg != PH_DELAY)
            begin
                action = ACT_GO;
                unique case (phase_reg)
                    PH_FRAME_PRE: phase_next = PH_IEN;
                    PH_IEN:       phase_next = PH_IRQ_RD;
                    PH_IRQ_RD:    phase_next = PH_IRQ_WR;
                    PH_IRQ_WR:    phase_next = PH_FL_RD;
                    PH_FL_RD:     phase_next = PH_FL_WR;
                    PH_FL_WR:     phase_next = PH_TX0;
                    PH_TX0:       phase_next = in_ac_reg ? PH_TX1 : PH_CMD;
                    PH_TX1:       phase_next = PH_CMD;
                    PH_CMD:       phase_next = PH_BF_RD;
                    PH_BF_RD:     phase_next = PH_BF_WR;
                    PH_BF_WR:
                    begin
                        poll_count_next = '0;
                        phase_next = (cfg.poll_limit == '0) ? PH_BFC_RD_T : PH_POLL;
                    end
                    PH_POLL:
                        phase_next = ((read_data & cfg.wait_irq_mask) != '0) ? PH_BFC_RD
                                                                             : PH_DELAY;
                    PH_BFC_RD:    phase_next = PH_BFC_WR;
                    PH_BFC_WR:    phase_next = PH_ERR;
                    PH_BFC_RD_T:  phase_next = PH_BFC_WR_T;
                    PH_BFC_WR_T:
                    begin
                        if (!in_ac_reg)
                            phase_next = PH_POST_TO;
                        else
                        begin
                            phase_next = PH_IDLE;
                            action     = ACT_FINISH;
                            fin_status = ST_TIMEOUT;
                        end
                    end
                    PH_ERR:
                    begin
                        if ((read_data & cfg.error_bit_mask) == '0)
                            phase_next = PH_LVL;
                        else if (!in_ac_reg)
                            phase_next = PH_POST_ERR;
                        else
                        begin
                            phase_next = PH_IDLE;
                            action     = ACT_FINISH;
                            fin_status = ST_ERROR;
                        end
                    end
                    PH_LVL:
                    begin
                        level_next = read_data[6:0];
                        phase_next = PH_CTRL;
                    end
                    PH_CTRL:
                    begin
                        // reply length kept wide: 127 bytes of level still fit
                        if (read_data[2:0] != 3'd0)
                            reply_bits_next = (level_reg == '0) ? '0 : {level_m1, read_data[2:0]};
                        else
                            reply_bits_next = {level_reg, 3'd0};
                        fifo_count_next = (level_reg > READ_MAX7) ? CNT_W'(FIFO_READ_MAX)
                                                                  : CNT_W'(level_reg);
                        byte_index_next = '0;
                        phase_next = (level_reg == '0) ? PH_IDLECMD : PH_FIFO;
                    end
                    PH_FIFO:
                    begin
                        // bytes past the fifth are read and dropped
                        if (byte_index_reg < NUM_KEPT3)
                        begin
                            store_en        = 1'b1;
                            byte_index_next = byte_index_reg + 3'd1;
                        end
                        fifo_count_next = fifo_dec;
                        phase_next = (fifo_dec == '0) ? PH_IDLECMD : PH_FIFO;
                    end
                    PH_IDLECMD:
                    begin
                        if (!in_ac_reg)
                            phase_next = PH_POST_OK;
                        else
                        begin
                            phase_next = PH_IDLE;
                            action     = ACT_FINISH;
                            if (reply_bits_reg < MIN_UID_BITS)
                                fin_status = ST_SHORT_UID;
                            else if (bcc != reply_bytes_reg[4])
                                fin_status = ST_BCC_FAIL;
                            else
                                fin_status = ST_OK;
                        end
                    end
                    PH_POST_OK:
                    begin
                        if (reply_bits_reg < MIN_REPLY_BITS)
                        begin
                            phase_next = PH_IDLE;
                            action     = ACT_FINISH;
                            fin_status = ST_SHORT_RPLY;
                        end
                        else
                        begin
                            in_ac_next = 1'b1;
                            phase_next = PH_FRAME_PRE;
                        end
                    end
                    PH_POST_TO:
                    begin
                        phase_next = PH_IDLE;
                        action     = ACT_FINISH;
                        fin_status = ST_TIMEOUT;
                    end
                    PH_POST_ERR:
                    begin
                        phase_next = PH_IDLE;
                        action     = ACT_FINISH;
                        fin_status = ST_ERROR;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                        action     = ACT_NONE;
                    end
                endcase
            end
        end
    end

    // result word for the phase just entered
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        if (action == ACT_FINISH)
        begin
            res_valid    = 1'b1;
            res.kind     = KIND_RESULT;
            res.status   = fin_status;
            res.card_uid = (fin_status == ST_OK) ? uid : '0;
        end
        else if (action == ACT_GO)
        begin
            res_valid = 1'b1;
            res.kind  = KIND_ACCESS;
            unique case (phase_next) inside
                PH_FRAME_PRE:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_BIT_FRAMING;
                    res.write_data = in_ac_next ? FRAME_FULL : FRAME_SHORT;
                end
                PH_IEN:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_COM_IEN;
                    res.write_data = {1'b1, cfg.irq_enable_bits};
                end
                PH_IRQ_RD, PH_POLL:
                    res.reg_addr = REG_COM_IRQ;
                PH_IRQ_WR:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_COM_IRQ;
                    res.write_data = read_data & LOW7_MASK;
                end
                PH_FL_RD, PH_LVL:
                    res.reg_addr = REG_FIFO_LEVEL;
                PH_FL_WR:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_FIFO_LEVEL;
                    res.write_data = read_data | BIT7_MASK;
                end
                PH_TX0:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_FIFO_DATA;
                    res.write_data = in_ac_next ? SEL_CASCADE1 : cfg.request_code;
                end
                PH_TX1:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_FIFO_DATA;
                    res.write_data = NVB_ANTICOLL;
                end
                PH_CMD:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_COMMAND;
                    res.write_data = RDR_CMD_TRANSCVE;
                end
                PH_BF_RD, PH_BFC_RD, PH_BFC_RD_T:
                    res.reg_addr = REG_BIT_FRAMING;
                PH_BF_WR:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_BIT_FRAMING;
                    res.write_data = read_data | BIT7_MASK;
                end
                PH_BFC_WR, PH_BFC_WR_T:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_BIT_FRAMING;
                    res.write_data = read_data & LOW7_MASK;
                end
                PH_DELAY:
                    res.kind = KIND_DELAY;
                PH_ERR:
                    res.reg_addr = REG_ERROR;
                PH_CTRL:
                    res.reg_addr = REG_CONTROL;
                PH_FIFO:
                    res.reg_addr = REG_FIFO_DATA;
                PH_IDLECMD:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_COMMAND;
                    res.write_data = RDR_CMD_IDLE;
                end
                PH_POST_OK, PH_POST_TO, PH_POST_ERR:
                begin
                    res.write_flag = 1'b1;
                    res.reg_addr   = REG_BIT_FRAMING;
                    res.write_data = FRAME_FULL;
                end
                default:
                    res_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            in_ac_reg      <= 1'b0;
            poll_count_reg <= '0;
            fifo_count_reg <= '0;
            byte_index_reg <= '0;
            level_reg      <= '0;
            reply_bits_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            in_ac_reg      <= in_ac_next;
            poll_count_reg <= poll_count_next;
            fifo_count_reg <= fifo_count_next;
            byte_index_reg <= byte_index_next;
            level_reg      <= level_next;
            reply_bits_reg <= reply_bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
            reply_bytes_reg[byte_index_reg] <= read_data;
    end

endmodule

// ===== hdl/contactless_uid_read_sequencer.sv =====
// top level of the card uid read sequencer: input register, step core, result register
//
// usage
//   in_item carries words from the host side: a start word launches a card read,
//   an access-completed word answers the last register access (read_data holds
//   the byte of a read), a delay-elapsed word answers a delay request.
//   out_item carries one word per useful input word: a reader register access
//   (write or read), a delay request, or the final result with status and
//   uid. words that make no sense in the current phase are dropped silently.
//   configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wr_data); the user
//   must write it only while no card read is in flight, the block does not enforce this.
// timing
//   an input word is taken into an input register, stepped through the
//   combinational sequencer step and its result lands in the output register.
//   one word per cycle is sustained while out_item keeps taking results.
// reset and stalls
//   reset returns the sequencer to idle and loads the default configuration.
//   while the output register holds an untaken result, the input register
//   still fills; further input is held off until the result is taken.
`timescale 1ns / 1ps

module contactless_uid_read_sequencer #(
    parameter int unsigned FIFO_READ_MAX = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cuid_in_if.sink                         in_item,
    cuid_out_if.source                      out_item,
    input  logic                            cfg_wr_en,
    input  logic [cuid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cuid_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import cuid_pkg::*;

    cuid_cfg_t  cfg;
    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_data_reg;
    logic       step_en;
    logic       res_valid;
    cuid_res_t  res;
    logic       out_valid_reg;
    cuid_res_t  out_reg;

    // step the held word only when the result slot is free or being drained
    assign step_en       = in_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready = !in_valid_reg || step_en;

    cuid_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    cuid_seq_core #(
        .FIFO_READ_MAX (FIFO_READ_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step_en   (step_en),
        .cmd       (in_cmd_reg),
        .read_data (in_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_item.ready)
                in_valid_reg <= in_item.valid;
            if (step_en)
                out_valid_reg <= res_valid;
            else if (out_item.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_item.ready && in_item.valid)
        begin
            in_cmd_reg  <= in_item.cmd;
            in_data_reg <= in_item.read_data;
        end
        if (step_en && res_valid)
            out_reg <= res;
    end

    assign out_item.valid      = out_valid_reg;
    assign out_item.kind       = out_reg.kind;
    assign out_item.write_flag = out_reg.write_flag;
    assign out_item.reg_addr   = out_reg.reg_addr;
    assign out_item.write_data = out_reg.write_data;
    assign out_item.status     = out_reg.status;
    assign out_item.card_uid   = out_reg.card_uid;

endmodule
